/* rtl/tsam_pkg.sv */
// ----------------------------------------------------------------------------
// tsam_pkg
// Shared types and codes for the tile scan address map block.
// ----------------------------------------------------------------------------
package tsam_pkg;

  // Shared unit sizing; covers tree-block counts up to 1024 per axis.
  localparam int ALU_OPND_W = 11;
  localparam int ALU_ACC_W  = 24;

  // Input word kinds (tuser)
  localparam logic [1:0] MODE_LOAD_COL = 2'd0;
  localparam logic [1:0] MODE_LOAD_ROW = 2'd1;
  localparam logic [1:0] MODE_MAP      = 2'd2;

  // Coordinate grain
  localparam logic [1:0] GRAIN_CTB    = 2'd0;
  localparam logic [1:0] GRAIN_MIN_CB = 2'd1;
  localparam logic [1:0] GRAIN_MIN_TB = 2'd2;

  // Largest transform ratio honored
  localparam logic [2:0] TB_RATIO_MAX = 3'd4;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_WIDTH   = 3'd0;
  localparam logic [2:0] REG_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_COLS    = 3'd2;
  localparam logic [2:0] REG_ROWS    = 3'd3;
  localparam logic [2:0] REG_UNIFORM = 3'd4;
  localparam logic [2:0] REG_LOG2_CB = 3'd5;
  localparam logic [2:0] REG_LOG2_TB = 3'd6;

  typedef struct packed {
    logic [9:0] width_in_ctbs;
    logic [9:0] height_in_ctbs;
    logic [5:0] tile_columns;
    logic [5:0] tile_rows;
    logic       uniform_spacing;
    logic [1:0] log2_ctb_over_min_cb;
    logic [2:0] log2_ctb_over_min_tb;
  } cfg_t;

  // Multiply-accumulate request: y = c +/- a*b
  typedef struct packed {
    logic                  sub;
    logic [ALU_ACC_W-1:0]  c;
    logic [ALU_OPND_W-1:0] a;
    logic [ALU_OPND_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_ACC_W-1:0] y;
    logic                 neg;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_AXIS_BEGIN,
    ST_U_P,
    ST_U_P2,
    ST_U_SCAN,
    ST_DIV_LO,
    ST_DIV_HI,
    ST_E_RD,
    ST_E_ACC,
    ST_E_CHK,
    ST_AXIS_END,
    ST_TS0,
    ST_TS1,
    ST_TS2,
    ST_TS3,
    ST_RA,
    ST_TN,
    ST_DONE
  } state_t;

endpackage

/* rtl/tsam_cfg.sv */
// ----------------------------------------------------------------------------
// tsam_cfg
// APB register file holding the picture and tile configuration.
// ----------------------------------------------------------------------------
module tsam_cfg
  import tsam_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_in_ctbs        <= 10'd1;
      cfg.height_in_ctbs       <= 10'd1;
      cfg.tile_columns         <= 6'd1;
      cfg.tile_rows            <= 6'd1;
      cfg.uniform_spacing      <= 1'b1;
      cfg.log2_ctb_over_min_cb <= 2'd0;
      cfg.log2_ctb_over_min_tb <= 3'd0;
    end else if (wr) begin
      unique case (paddr[4:2])
        REG_WIDTH:   cfg.width_in_ctbs        <= pwdata[9:0];
        REG_HEIGHT:  cfg.height_in_ctbs       <= pwdata[9:0];
        REG_COLS:    cfg.tile_columns         <= pwdata[5:0];
        REG_ROWS:    cfg.tile_rows            <= pwdata[5:0];
        REG_UNIFORM: cfg.uniform_spacing      <= pwdata[0];
        REG_LOG2_CB: cfg.log2_ctb_over_min_cb <= pwdata[1:0];
        REG_LOG2_TB: cfg.log2_ctb_over_min_tb <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_WIDTH:   prdata = 32'(cfg.width_in_ctbs);
      REG_HEIGHT:  prdata = 32'(cfg.height_in_ctbs);
      REG_COLS:    prdata = 32'(cfg.tile_columns);
      REG_ROWS:    prdata = 32'(cfg.tile_rows);
      REG_UNIFORM: prdata = 32'(cfg.uniform_spacing);
      REG_LOG2_CB: prdata = 32'(cfg.log2_ctb_over_min_cb);
      REG_LOG2_TB: prdata = 32'(cfg.log2_ctb_over_min_tb);
      default:     prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/tsam_alu.sv */
// ----------------------------------------------------------------------------
// tsam_alu
// Shared multiply-accumulate unit, y = c + a*b or c - a*b.
// ----------------------------------------------------------------------------
module tsam_alu
  import tsam_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [2*ALU_OPND_W-1:0] prod;
  logic [ALU_ACC_W-1:0]    sum;

  assign prod = req.a * req.b;
  assign sum  = req.sub ? (req.c - ALU_ACC_W'(prod)) : (req.c + ALU_ACC_W'(prod));

  assign rsp.y   = sum;
  assign rsp.neg = sum[ALU_ACC_W-1];

endmodule

/* rtl/tsam_tables.sv */
// ----------------------------------------------------------------------------
// tsam_tables
// Explicit tile column width and row height memories, registered read.
// ----------------------------------------------------------------------------
module tsam_tables #(
  parameter int DEPTH = 32,
  parameter int IW    = 5
) (
  input  logic          clk,
  input  logic          col_we,
  input  logic          row_we,
  input  logic [IW-1:0] wr_addr,
  input  logic [9:0]    wr_data,
  input  logic          rd_axis,
  input  logic [IW-1:0] rd_addr,
  output logic [9:0]    rd_data
);

  logic [9:0] col_mem [DEPTH];
  logic [9:0] row_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[wr_addr] <= wr_data;
    end
    if (row_we) begin
      row_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_axis) begin
      rd_data <= row_mem[rd_addr];
    end else begin
      rd_data <= col_mem[rd_addr];
    end
  end

endmodule

/* rtl/tile_scan_address_map.sv */
// ----------------------------------------------------------------------------
// tile_scan_address_map
// Picture block coordinate to raster, tile-scan, tile number and z-scan
// address, with loadable explicit tile widths and heights.
// ----------------------------------------------------------------------------
// Load words (column width, row height) are taken without holding the input
// and give no result; a load index past the table is dropped. A map word is
// processed by one shared multiply-accumulate unit under a small sequencer,
// and s_tready is low until its result has been placed in the output
// register. A map makes one pass per axis (columns, then rows). With uniform
// spacing the tile is located by stepping multiples of the axis size, then
// its two bounds come out of a restoring division, one quotient bit a cycle
// on the shared unit. With explicit spacing a pass adds up table entries in
// turn until the running bound passes the position or the last tile is
// reached, each entry taking an accumulate state and, unless it is the last,
// a check state around the registered table read. A coordinate outside the
// picture skips both passes and returns with out_of_range set and the
// address fields zero. The output register lets the next word be accepted
// while a result waits for m_tready. Explicit table entries have no reset:
// a map in explicit mode must only reach entries that have been loaded.
// ----------------------------------------------------------------------------
module tile_scan_address_map
  import tsam_pkg::*;
#(
  parameter int MAX_TILES_PER_AXIS = 32,
  parameter int MAX_CTBS_PER_AXIS  = 512
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [4:0] table_index, [14:5] table_value, [16:15] grain,
  // [29:17] block_x, [42:30] block_y, [47:43] zero
  input  logic [47:0] s_tdata,
  // [1:0] mode
  input  logic [1:0]  s_tuser,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [17:0] raster_address, [35:18] tile_scan_address,
  // [45:36] tile_number, [71:46] z_scan_address
  output logic [71:0] m_tdata,
  // [0] out_of_range
  output logic [0:0]  m_tuser,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // CW: tree-block count width, NW: tile count width, TIW: tile index width
  localparam int CW  = $clog2(MAX_CTBS_PER_AXIS + 1);
  localparam int NW  = $clog2(MAX_TILES_PER_AXIS + 1);
  localparam int TIW = (MAX_TILES_PER_AXIS > 1) ? $clog2(MAX_TILES_PER_AXIS) : 1;
  localparam int OW  = ALU_OPND_W;
  localparam int AW  = ALU_ACC_W;

  cfg_t     cfg;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  state_t   state, state_next;

  // input word fields
  logic [1:0]  in_mode;
  logic [4:0]  in_tidx;
  logic [9:0]  in_tval;
  logic [1:0]  in_grain;
  logic [12:0] in_bx;
  logic [12:0] in_by;
  logic [6:0]  tidx_ext;
  logic        idx_ok;
  logic        accept;
  logic        map_accept;
  logic        col_we;
  logic        row_we;

  // clamped configuration at map start
  logic [10:0] w_clamp;
  logic [10:0] h_clamp;
  logic [6:0]  nc_clamp;
  logic [6:0]  nr_clamp;
  logic [2:0]  d_sel;

  // per-map registers
  logic [CW-1:0]  w_r;
  logic [CW-1:0]  h_r;
  logic [NW-1:0]  nc_r;
  logic [NW-1:0]  nr_r;
  logic [2:0]     d_r;
  logic [12:0]    tx_r;
  logic [12:0]    ty_r;
  logic [3:0]     bx_lo;
  logic [3:0]     by_lo;
  logic           oor_r;
  logic           oor;
  logic [CW-1:0]  tx_c;
  logic [CW-1:0]  ty_c;

  // axis search registers
  logic           axis;
  logic [TIW-1:0] i;
  logic [CW-1:0]  s;
  logic [AW-1:0]  acc;
  logic [AW-1:0]  p_r;
  logic [AW-1:0]  prev_a;
  logic [AW-1:0]  hi_a;
  logic [CW-1:0]  q;
  logic [CW-1:0]  qmask;
  logic [TIW-1:0] ax_idx;
  logic [CW-1:0]  ax_lo;
  logic [CW-1:0]  ax_hi;
  logic [TIW-1:0] col_idx;
  logic [CW-1:0]  col_lo;
  logic [CW-1:0]  col_hi;
  logic [TIW-1:0] row_idx;
  logic [CW-1:0]  row_lo;
  logic [CW-1:0]  row_hi;
  logic [25:0]    ts_r;
  logic [17:0]    ra_r;

  // axis view
  logic [CW-1:0]  ax_pos;
  logic [NW-1:0]  ax_n;
  logic [CW-1:0]  ax_total;
  logic           last_tile;
  logic           scan_hit;
  logic [CW-1:0]  qstep;
  logic [CW-1:0]  s_sat;
  logic [CW-1:0]  qmask_top;

  // table port
  logic [TIW-1:0] rd_addr;
  logic [9:0]     rd_data;

  // output
  logic           load_out;
  logic [25:0]    z_il;
  logic [25:0]    z_full;

  tsam_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tsam_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  tsam_tables #(
    .DEPTH (MAX_TILES_PER_AXIS),
    .IW    (TIW)
  ) u_tables (
    .clk     (clk),
    .col_we  (col_we),
    .row_we  (row_we),
    .wr_addr (tidx_ext[TIW-1:0]),
    .wr_data (in_tval),
    .rd_axis (axis),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // --------------------------------------------------------------------------
  // Input decode. Loads are written straight into the tables while idle.
  // --------------------------------------------------------------------------
  assign in_mode  = s_tuser;
  assign in_tidx  = s_tdata[4:0];
  assign in_tval  = s_tdata[14:5];
  assign in_grain = s_tdata[16:15];
  assign in_bx    = s_tdata[29:17];
  assign in_by    = s_tdata[42:30];

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign map_accept = accept && (in_mode == MODE_MAP);
  assign tidx_ext   = 7'(in_tidx);
  assign idx_ok     = tidx_ext < 7'(MAX_TILES_PER_AXIS);
  assign col_we     = accept && (in_mode == MODE_LOAD_COL) && idx_ok;
  assign row_we     = accept && (in_mode == MODE_LOAD_ROW) && idx_ok;

  // Zero counts read as one, oversize counts saturate.
  always_comb begin
    if (cfg.width_in_ctbs == 10'd0) begin
      w_clamp = 11'd1;
    end else if (11'(cfg.width_in_ctbs) > 11'(MAX_CTBS_PER_AXIS)) begin
      w_clamp = 11'(MAX_CTBS_PER_AXIS);
    end else begin
      w_clamp = 11'(cfg.width_in_ctbs);
    end
    if (cfg.height_in_ctbs == 10'd0) begin
      h_clamp = 11'd1;
    end else if (11'(cfg.height_in_ctbs) > 11'(MAX_CTBS_PER_AXIS)) begin
      h_clamp = 11'(MAX_CTBS_PER_AXIS);
    end else begin
      h_clamp = 11'(cfg.height_in_ctbs);
    end
    if (cfg.tile_columns == 6'd0) begin
      nc_clamp = 7'd1;
    end else if (7'(cfg.tile_columns) > 7'(MAX_TILES_PER_AXIS)) begin
      nc_clamp = 7'(MAX_TILES_PER_AXIS);
    end else begin
      nc_clamp = 7'(cfg.tile_columns);
    end
    if (cfg.tile_rows == 6'd0) begin
      nr_clamp = 7'd1;
    end else if (7'(cfg.tile_rows) > 7'(MAX_TILES_PER_AXIS)) begin
      nr_clamp = 7'(MAX_TILES_PER_AXIS);
    end else begin
      nr_clamp = 7'(cfg.tile_rows);
    end
  end

  // Grain shift; an undefined grain code acts as tree-block grain.
  always_comb begin
    unique case (in_grain)
      GRAIN_MIN_CB: d_sel = 3'(cfg.log2_ctb_over_min_cb);
      GRAIN_MIN_TB: d_sel = (cfg.log2_ctb_over_min_tb > TB_RATIO_MAX) ?
                            TB_RATIO_MAX : cfg.log2_ctb_over_min_tb;
      default:      d_sel = 3'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Axis view: the column pass and the row pass share one search datapath.
  // --------------------------------------------------------------------------
  assign tx_c      = tx_r[CW-1:0];
  assign ty_c      = ty_r[CW-1:0];
  assign oor       = (tx_r >= 13'(w_r)) || (ty_r >= 13'(h_r));
  assign ax_pos    = axis ? ty_c : tx_c;
  assign ax_n      = axis ? nr_r : nc_r;
  assign ax_total  = axis ? h_r : w_r;
  assign last_tile = (NW'(i) == (ax_n - NW'(1)));
  // uniform: pos < floor(k*total/n) exactly when k*total >= (pos+1)*n
  assign scan_hit  = (acc >= p_r) || last_tile;
  assign qstep     = q | (alu_rsp.neg ? '0 : qmask);
  assign qmask_top = CW'(1) << (CW - 1);
  // explicit: running bound saturates at the axis size
  assign s_sat     = (acc > AW'(ax_total)) ? ax_total : acc[CW-1:0];
  assign rd_addr   = (state == ST_E_CHK) ? (i + TIW'(1)) : i;

  // --------------------------------------------------------------------------
  // Shared unit operand selection
  // --------------------------------------------------------------------------
  always_comb begin
    alu_req = '0;
    case (state)
      ST_U_P: begin
        alu_req.a = OW'(ax_pos) + OW'(1);
        alu_req.b = OW'(ax_n);
      end
      ST_U_P2: begin
        alu_req.a = OW'(ax_total);
        alu_req.b = OW'(1);
      end
      ST_U_SCAN: begin
        alu_req.c = acc;
        alu_req.a = OW'(ax_total);
        alu_req.b = OW'(1);
      end
      ST_DIV_LO, ST_DIV_HI: begin
        // trial subtract of n at the current quotient weight
        alu_req.sub = 1'b1;
        alu_req.c   = acc;
        alu_req.a   = OW'(ax_n);
        alu_req.b   = OW'(qmask);
      end
      ST_E_ACC: begin
        alu_req.c = AW'(s);
        alu_req.a = OW'(rd_data);
        alu_req.b = OW'(1);
      end
      // tile scan address:
      //   w*rlo + (rhi-rlo)*clo + (ty-rlo)*(chi-clo) + (tx-clo)
      ST_TS0: begin
        alu_req.a = OW'(w_r);
        alu_req.b = OW'(row_lo);
      end
      ST_TS1: begin
        alu_req.c = acc;
        alu_req.a = OW'(row_hi - row_lo);
        alu_req.b = OW'(col_lo);
      end
      ST_TS2: begin
        alu_req.c = acc;
        alu_req.a = OW'(ty_c - row_lo);
        alu_req.b = OW'(col_hi - col_lo);
      end
      ST_TS3: begin
        alu_req.c = acc;
        alu_req.a = OW'(tx_c - col_lo);
        alu_req.b = OW'(1);
      end
      ST_RA: begin
        alu_req.c = AW'(tx_c);
        alu_req.a = OW'(ty_c);
        alu_req.b = OW'(w_r);
      end
      ST_TN: begin
        alu_req.c = AW'(col_idx);
        alu_req.a = OW'(row_idx);
        alu_req.b = OW'(nc_r);
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE:       if (map_accept) state_next = ST_START;
      ST_START:      state_next = oor ? ST_DONE : ST_AXIS_BEGIN;
      ST_AXIS_BEGIN: state_next = cfg.uniform_spacing ? ST_U_P : ST_E_RD;
      ST_U_P:        state_next = ST_U_P2;
      ST_U_P2:       state_next = ST_U_SCAN;
      ST_U_SCAN:     if (scan_hit) state_next = ST_DIV_LO;
      ST_DIV_LO:     if (qmask[0]) state_next = ST_DIV_HI;
      ST_DIV_HI:     if (qmask[0]) state_next = ST_AXIS_END;
      ST_E_RD:       state_next = ST_E_ACC;
      ST_E_ACC:      state_next = last_tile ? ST_AXIS_END : ST_E_CHK;
      ST_E_CHK:      state_next = (ax_pos < s_sat) ? ST_AXIS_END : ST_E_ACC;
      ST_AXIS_END:   state_next = axis ? ST_TS0 : ST_AXIS_BEGIN;
      ST_TS0:        state_next = ST_TS1;
      ST_TS1:        state_next = ST_TS2;
      ST_TS2:        state_next = ST_TS3;
      ST_TS3:        state_next = ST_RA;
      ST_RA:         state_next = ST_TN;
      ST_TN:         state_next = ST_DONE;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default:       state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (map_accept) begin
      w_r   <= w_clamp[CW-1:0];
      h_r   <= h_clamp[CW-1:0];
      nc_r  <= nc_clamp[NW-1:0];
      nr_r  <= nr_clamp[NW-1:0];
      d_r   <= d_sel;
      tx_r  <= in_bx >> d_sel;
      ty_r  <= in_by >> d_sel;
      bx_lo <= in_bx[3:0];
      by_lo <= in_by[3:0];
    end
    case (state)
      ST_START: begin
        axis  <= 1'b0;
        oor_r <= oor;
      end
      ST_AXIS_BEGIN: begin
        i <= '0;
        s <= '0;
      end
      ST_U_P: begin
        acc <= alu_rsp.y;
      end
      ST_U_P2: begin
        p_r    <= acc;
        prev_a <= '0;
        acc    <= alu_rsp.y;
      end
      ST_U_SCAN: begin
        if (scan_hit) begin
          hi_a   <= acc;
          acc    <= prev_a;
          ax_idx <= i;
          q      <= '0;
          qmask  <= qmask_top;
        end else begin
          prev_a <= acc;
          acc    <= alu_rsp.y;
          i      <= i + TIW'(1);
        end
      end
      ST_DIV_LO: begin
        q     <= qstep;
        qmask <= qmask >> 1;
        if (!alu_rsp.neg) begin
          acc <= alu_rsp.y;
        end
        if (qmask[0]) begin
          ax_lo <= qstep;
          acc   <= hi_a;
          q     <= '0;
          qmask <= qmask_top;
        end
      end
      ST_DIV_HI: begin
        q     <= qstep;
        qmask <= qmask >> 1;
        if (!alu_rsp.neg) begin
          acc <= alu_rsp.y;
        end
        if (qmask[0]) begin
          ax_hi <= qstep;
        end
      end
      ST_E_ACC: begin
        if (last_tile) begin
          // last tile takes the remainder
          ax_idx <= i;
          ax_lo  <= s;
          ax_hi  <= ax_total;
        end else begin
          acc <= alu_rsp.y;
        end
      end
      ST_E_CHK: begin
        if (ax_pos < s_sat) begin
          ax_idx <= i;
          ax_lo  <= s;
          ax_hi  <= s_sat;
        end else begin
          s <= s_sat;
          i <= i + TIW'(1);
        end
      end
      ST_AXIS_END: begin
        if (axis) begin
          row_idx <= ax_idx;
          row_lo  <= ax_lo;
          row_hi  <= ax_hi;
        end else begin
          col_idx <= ax_idx;
          col_lo  <= ax_lo;
          col_hi  <= ax_hi;
          axis    <= 1'b1;
        end
      end
      ST_TS0, ST_TS1, ST_TS2, ST_TS3: begin
        acc <= alu_rsp.y;
      end
      ST_RA: begin
        ts_r <= 26'(acc);
        acc  <= alu_rsp.y;
      end
      ST_TN: begin
        ra_r <= acc[17:0];
        acc  <= alu_rsp.y;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Z-scan: x bit k at weight 4^k, y bit k at 2*4^k, below the shifted
  // tile-scan address.
  // --------------------------------------------------------------------------
  always_comb begin
    z_il = '0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < d_r) begin
        z_il[2*k]     = bx_lo[k];
        z_il[2*k + 1] = by_lo[k];
      end
    end
    z_full = (ts_r << {d_r, 1'b0}) | z_il;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tuser <= oor_r;
      if (oor_r) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {z_full, acc[9:0], ts_r[17:0], ra_r};
      end
    end
  end

endmodule

/* rtl/tsam_checker.sv */
// ----------------------------------------------------------------------------
// tsam_checker
// Port-level checks on the tile scan address map, bound to the top level.
// ----------------------------------------------------------------------------
module tsam_checker
  import tsam_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [47:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // out-of-picture results carry zero addresses
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("out-of-range result with nonzero fields");

  // a map word occupies the sequencer
  a_map_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == MODE_MAP |=> !s_tready)
    else $error("input ready right after a map word");

  // load and ignored words leave the input ready
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != MODE_MAP |=> s_tready)
    else $error("input stalled after a load word");

  // a new result only follows a busy sequencer
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result word without a map in progress");

endmodule

bind tile_scan_address_map tsam_checker u_checker (.*);
